// ===== rtl/core/spie_pkg.sv =====
// Package for the step pulse item encoder: request and result words,
// sequencer states and the shared subtractor result. No dependencies.
package spie_pkg;

  localparam int DurW  = 15;
  localparam int SlotW = 6;
  localparam int CntW  = 7;
  localparam int WordW = 32;

  typedef struct packed {
    logic             action;
    logic [WordW-1:0] step_period;
    logic [WordW-1:0] pulse_width;
  } req_t;

  typedef struct packed {
    logic             item_valid;
    logic             level_first;
    logic [DurW-1:0]  dur_first;
    logic             level_second;
    logic [DurW-1:0]  dur_second;
    logic [SlotW-1:0] slot;
    logic             overflow;
    logic             last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CLAMP = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  typedef struct packed {
    logic [WordW-1:0] diff;
    logic             borrow;
    logic             zero;
  } alu_res_t;

endpackage

// ===== rtl/core/spie_alu.sv =====
// Shared 32-bit subtractor with borrow and zero flags.
// Depends on spie_pkg.
module spie_alu (
  input  logic [spie_pkg::WordW-1:0] a,
  input  logic [spie_pkg::WordW-1:0] b,
  output spie_pkg::alu_res_t         res
);

  logic [spie_pkg::WordW:0] full_diff;

  assign full_diff  = {1'b0, a} - {1'b0, b};
  assign res.diff   = full_diff[spie_pkg::WordW-1:0];
  assign res.borrow = full_diff[spie_pkg::WordW];
  assign res.zero   = (full_diff[spie_pkg::WordW-1:0] == '0);

endmodule

// ===== rtl/core/step_pulse_item_encoder_top.sv =====
// Step pulse item encoder top level: sequencer around one shared subtractor.
// Depends on spie_pkg and spie_alu.
//
// channel        | direction | handshake                 | payload
// request        | in        | req_valid / req_stall     | req (spie_pkg::req_t)
// result         | out       | res_valid / res_stall     | res (spie_pkg::res_t)
// slot capacity  | in        | slot_capacity_we          | slot_capacity (7 bits)
//
// A clear request zeroes the slot count; the sequencer stays idle. An append
// request clamps the pulse in S_CLAMP, then emits one result item per cycle
// from the shared subtractor in S_EMIT unless res_stall holds the result. For
// an append, req_stall is high from acceptance until the last result is loaded.
// Reset (rst, synchronous) empties the result register, zeroes the slot count
// and sets the capacity to 64.
module step_pulse_item_encoder_top #(
  parameter int SLOTS        = 64,
  parameter int MAX_DURATION = 32767
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  spie_pkg::req_t             req,
  output logic                       res_valid,
  input  logic                       res_stall,
  output spie_pkg::res_t             res,
  input  logic                       slot_capacity_we,
  input  logic [spie_pkg::CntW-1:0]  slot_capacity
);

  localparam logic [spie_pkg::CntW-1:0]  SlotsCap = spie_pkg::CntW'(SLOTS);
  localparam logic [spie_pkg::WordW-1:0] MaxDur32 = spie_pkg::WordW'(MAX_DURATION);
  localparam logic [spie_pkg::DurW-1:0]  MaxDur   = spie_pkg::DurW'(MAX_DURATION);

  spie_pkg::state_t           state;
  logic [spie_pkg::WordW-1:0] period;
  logic [spie_pkg::WordW-1:0] pulse;
  logic [spie_pkg::WordW-1:0] low;
  logic [spie_pkg::DurW-1:0]  pulse_dur;
  logic                       first;
  logic [spie_pkg::CntW-1:0]  used;
  logic [spie_pkg::CntW-1:0]  capacity;

  logic [spie_pkg::CntW-1:0]  cap;
  logic [spie_pkg::CntW-1:0]  used_inc;
  logic [spie_pkg::DurW-1:0]  chunk;
  logic [spie_pkg::WordW-1:0] pulse_eff;
  logic [spie_pkg::WordW-1:0] alu_a;
  logic [spie_pkg::WordW-1:0] alu_b;
  logic                       out_free;
  logic                       done;
  spie_pkg::alu_res_t         alu;

  spie_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu)
  );

  assign req_stall = (state != spie_pkg::S_IDLE);
  assign cap       = (capacity > SlotsCap) ? SlotsCap : capacity;
  assign used_inc  = used + spie_pkg::CntW'(1);
  assign chunk     = (low > MaxDur32) ? MaxDur : low[spie_pkg::DurW-1:0];
  assign alu_a     = (state == spie_pkg::S_CLAMP) ? period : low;
  assign alu_b     = (state == spie_pkg::S_CLAMP) ? pulse : spie_pkg::WordW'(chunk);
  assign pulse_eff = alu.borrow ? period : pulse;
  assign out_free  = !res_valid || !res_stall;
  assign done      = alu.zero || (used_inc >= cap);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= SlotsCap;
    end else if (slot_capacity_we) begin
      capacity <= slot_capacity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == spie_pkg::S_EMIT) && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spie_pkg::S_IDLE;
      used      <= '0;
      first     <= 1'b0;
    end else begin
      unique case (state)
        spie_pkg::S_IDLE: begin
          if (req_valid) begin
            if (req.action) begin
              used <= '0;
            end else begin
              period <= req.step_period;
              pulse  <= (req.pulse_width == '0) ? spie_pkg::WordW'(1) : req.pulse_width;
              state  <= spie_pkg::S_CLAMP;
            end
          end
        end
        spie_pkg::S_CLAMP: begin
          low       <= alu.borrow ? '0 : alu.diff;
          pulse_dur <= (pulse_eff > MaxDur32) ? MaxDur : pulse_eff[spie_pkg::DurW-1:0];
          first     <= 1'b1;
          state     <= spie_pkg::S_EMIT;
        end
        spie_pkg::S_EMIT: begin
          if (out_free) begin
            if (first && (used >= cap)) begin
              res   <= '{overflow: 1'b1, last: 1'b1, default: '0};
              state <= spie_pkg::S_IDLE;
            end else begin
              res.item_valid   <= 1'b1;
              res.level_first  <= first;
              res.dur_first    <= first ? pulse_dur : chunk;
              res.level_second <= 1'b0;
              res.dur_second   <= first ? chunk : spie_pkg::DurW'(1);
              res.slot         <= used[spie_pkg::SlotW-1:0];
              res.overflow     <= done && !alu.zero;
              res.last         <= done;
              used             <= used_inc;
              low              <= alu.diff;
              first            <= 1'b0;
              if (done) begin
                state <= spie_pkg::S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= spie_pkg::S_IDLE;
        end
      endcase
    end
  end

  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used <= SlotsCap)
    else $error("slot count beyond buffer size");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.item_valid |-> {1'b0, res.slot} < cap)
    else $error("item written beyond capacity");

  a_overflow_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.overflow |-> res.last)
    else $error("overflow on a result that is not last");

  a_empty_item: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.item_valid |-> res.overflow && res.last)
    else $error("empty result without overflow");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    state == spie_pkg::S_EMIT && out_free && done |=> state == spie_pkg::S_IDLE)
    else $error("sequencer kept running after last item");

endmodule
